// ----- design/metropolis_accept_with_cooling_unit_defines.svh -----
// Assertion macros shared by the metropolis acceptance unit.
`ifndef METROPOLIS_ACCEPT_WITH_COOLING_UNIT_DEFINES_SVH
`define METROPOLIS_ACCEPT_WITH_COOLING_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define MAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/mac_pkg.sv -----
// ----------------------------------------------------------------------------
// mac_pkg
// Types and constants of the metropolis acceptance unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mac_pkg;
  localparam logic [1:0] REG_START_TEMP = 2'd0;
  localparam logic [1:0] REG_COOL_FACTOR = 2'd1;
  localparam logic [1:0] REG_COOL_PERIOD = 2'd2;
  localparam logic [31:0] START_TEMP_RST = 32'd6553600;
  localparam logic [15:0] COOL_FACTOR_RST = 16'd62259;
  localparam logic [15:0] COOL_PERIOD_RST = 16'd100;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [16:0] PROB_ONE = 17'd65536;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_log;
    logic interp;
    logic finish;
  } mac_cmd_t;

  typedef struct packed {
    logic div_done;
  } mac_sts_t;
endpackage
`default_nettype wire

// ----- design/mac_if.sv -----
// ----------------------------------------------------------------------------
// mac_if
// Valid/ready channel interface with a generic payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface mac_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/mac_ctrl.sv -----
// ----------------------------------------------------------------------------
// mac_ctrl
// Sequencer for one item: load, divide, log2e scaling, interpolation, output.
// ----------------------------------------------------------------------------
`default_nettype none
module mac_ctrl
  import mac_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  input  mac_sts_t  sts_i,
  output mac_cmd_t  cmd_o
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DIV = 6'b000010, S_MUL = 6'b000100,
    S_INT = 6'b001000, S_FIN = 6'b010000, S_OUT = 6'b100000
  } state_e;
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_log = 1'b1;
        state_d = S_INT;
      end
      S_INT: begin
        cmd_o.interp = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

`include "metropolis_accept_with_cooling_unit_defines.svh"
  `MAC_ASSERT_IMP(a_oh, clk_i, rst_ni, 1'b1, $onehot(state_q), "state not one-hot")
  `MAC_ASSERT_NEXT(a_ld, clk_i, rst_ni, cmd_o.load, state_q == S_DIV, "load did not divide")
  `MAC_ASSERT_IMP(a_rv, clk_i, rst_ni, out_valid_o, !in_ready_o, "accept while holding")
endmodule
`default_nettype wire

// ----- design/mac_dp.sv -----
// ----------------------------------------------------------------------------
// mac_dp
// Datapath: restoring divider, exp2 table with interpolation, state update.
// ----------------------------------------------------------------------------
`default_nettype none
module mac_dp
  import mac_pkg::*;
#(
  parameter int EXP_TABLE_BITS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  mac_cmd_t    cmd_i,
  output mac_sts_t    sts_o,
  input  wire  [31:0] cur_i,
  input  wire  [31:0] prop_i,
  input  wire  [15:0] sample_i,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [31:0] cfg_data_i,
  output logic        accepted_o,
  output logic [16:0] prob_o,
  output logic [31:0] temp_used_o,
  output logic [31:0] total_o
);
  localparam int TS = (1 << EXP_TABLE_BITS) + 1;
  localparam int SH = 16 - EXP_TABLE_BITS;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b, w;
    r = '0; b = 64'd1 << 62; w = v;
    for (int k = 0; k < 32; k++) begin
      if (w >= r + b) begin w = w - (r + b); r = (r >> 1) + b; end
      else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [TS*33-1:0] mk_tbl();
    logic [TS*33-1:0] t;
    logic [63:0] root, p;
    logic [127:0] m;
    root = 64'd1 << 31;
    for (int k = 0; k < EXP_TABLE_BITS; k++) root = isqrt(root << 32);
    p = 64'd1 << 32;
    t = '0;
    for (int k = 0; k < TS; k++) begin
      t[k*33 +: 33] = p[32:0];
      m = p * root + (128'd1 << 31);
      p = m[95:32];
    end
    return t;
  endfunction
  localparam logic [TS*33-1:0] TBL = mk_tbl();

  logic [31:0] temp_q, total_q, t_used_q;
  logic [15:0] factor_q, period_q, cnt_q;
  logic [15:0] sample_q;
  logic        pos_q, tz_q;
  logic [48:0] rem_q;
  logic [48:0] quo_q;
  logic [5:0]  step_q;
  logic [21:0] x_q;
  logic        big_q;
  logic [38:0] y_q;
  logic [16:0] prob_q;
  logic        acc_now;

  logic [32:0] d;
  assign d = {prop_i[31], prop_i} - {cur_i[31], cur_i};
  assign sts_o.div_done = (step_q == 6'd48);

  logic [49:0] trial;
  assign trial = {rem_q, quo_q[48]} - {18'd0, t_used_q};

  logic [EXP_TABLE_BITS-1:0] idx;
  logic [SH-1:0]            frac;
  logic [32:0]              e0, e1, dif;
  logic [32+SH:0]           prodi;
  logic [32:0]              val;
  logic [6:0]               n;
  logic [32:0]              vsh;
  assign n = y_q[38:32];
  assign idx = y_q[31-:EXP_TABLE_BITS];
  assign frac = y_q[16 +: SH];
  assign e0 = TBL[idx*33 +: 33];
  assign e1 = TBL[(idx+1)*33 +: 33];
  assign dif = e0 - e1;
  assign prodi = dif * frac;
  assign val = e0 - 33'(prodi >> SH);
  assign vsh = val >> (7'd16 + n);

  logic [16:0] next_cnt;
  logic [47:0] cool;
  assign next_cnt = {1'b0, cnt_q} + 17'd1;
  assign cool = temp_q * factor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= START_TEMP_RST;
      factor_q <= COOL_FACTOR_RST; period_q <= COOL_PERIOD_RST;
      cnt_q <= '0; total_q <= '0; step_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_START_TEMP: temp_q <= cfg_data_i;
          REG_COOL_FACTOR: factor_q <= cfg_data_i[15:0];
          REG_COOL_PERIOD: period_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        step_q <= '0;
        if (next_cnt >= {1'b0, period_q}) begin
          cnt_q <= '0; temp_q <= cool[47:16];
        end else cnt_q <= next_cnt[15:0];
      end else if (cmd_i.div_step && step_q != 6'd48) step_q <= step_q + 6'd1;
      if (cmd_i.finish && acc_now && total_q != 32'hFFFFFFFF) total_q <= total_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_used_q <= temp_q; sample_q <= sample_i;
      tz_q <= (temp_q == '0);
      pos_q <= ~d[32] && (d != '0);
      rem_q <= '0; quo_q <= {d[31:0], 17'd0};
    end
    if (cmd_i.div_step && step_q != 6'd48) begin
      if (!trial[49]) begin
        rem_q <= trial[48:0]; quo_q <= {quo_q[47:0], 1'b1};
      end else begin
        rem_q <= {rem_q[47:0], quo_q[48]}; quo_q <= {quo_q[47:0], 1'b0};
      end
    end
    if (cmd_i.mul_log) begin
      big_q <= (quo_q[48:22] != '0);
      x_q <= quo_q[21:0];
    end
    if (cmd_i.interp) y_q <= x_q * LOG2E_Q16;
    if (cmd_i.finish) begin
      if (tz_q || !pos_q) prob_q <= pos_q ? 17'd0 : PROB_ONE;
      else if (big_q || n > 7'd16) prob_q <= 17'd0;
      else prob_q <= (vsh > 33'(PROB_ONE)) ? PROB_ONE : vsh[16:0];
    end
  end

  always_comb begin
    if (tz_q || !pos_q) acc_now = pos_q ? (sample_q == '0) : 1'b1;
    else if (big_q || n > 7'd16) acc_now = (sample_q == '0);
    else acc_now = ({1'b0, sample_q} <= ((vsh > 33'(PROB_ONE)) ? PROB_ONE : vsh[16:0]));
  end

  assign prob_o = prob_q;
  assign accepted_o = {1'b0, sample_q} <= prob_q;
  assign temp_used_o = t_used_q;
  assign total_o = total_q;

`include "metropolis_accept_with_cooling_unit_defines.svh"
  `MAC_ASSERT_IMP(a_pr, clk_i, rst_ni, cmd_i.mul_log, step_q == 6'd48, "divide not done")
  `MAC_ASSERT_NEXT(a_tc, clk_i, rst_ni, cmd_i.finish && !acc_now, $stable(total_q), "bad count")
endmodule
`default_nettype wire

// ----- design/metropolis_accept_with_cooling_unit.sv -----
// ----------------------------------------------------------------------------
// metropolis_accept_with_cooling_unit
// Metropolis acceptance test with geometric cooling of the temperature.
// ----------------------------------------------------------------------------
// One input beat carries current and proposed energy and a uniform sample.
// One output beat per input carries the decision, the probability, the
// temperature applied and the running acceptance total.
// Output valid rises after the restoring divider (48 quotient bits, one per
// cycle, and a final check that it is done), then log2e scaling, table
// interpolation and result registration.
// The block holds one item at a time and takes no new input until the
// result beat has been taken.
// Reset loads the default registers, the start temperature and clears the
// period counter and the acceptance total.
// While the receiver stalls, the result beat holds and no input is taken.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.
// ----------------------------------------------------------------------------
`default_nettype none
module metropolis_accept_with_cooling_unit
  import mac_pkg::*;
#(
  parameter int EXP_TABLE_BITS = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  mac_if.sink        in_if,
  mac_if.source      out_if,
  input  wire        cfg_we_i,
  input  wire [1:0]  cfg_idx_i,
  input  wire [31:0] cfg_data_i
);
  mac_cmd_t cmd;
  mac_sts_t sts;
  logic        acc;
  logic [16:0] prob;
  logic [31:0] tu, tot;

  mac_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  mac_dp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cur_i(in_if.data[79:48]), .prop_i(in_if.data[47:16]), .sample_i(in_if.data[15:0]),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .accepted_o(acc), .prob_o(prob), .temp_used_o(tu), .total_o(tot)
  );

  assign out_if.data = {acc, prob, tu, tot};
endmodule
`default_nettype wire

// ----- bench/metropolis_accept_with_cooling_unit_test.sv -----
// ----------------------------------------------------------------------------
// metropolis_accept_with_cooling_unit_test
// Self-checking bench for the Metropolis acceptance unit. A local model of
// the probability, the cooling and the acceptance total predicts every result
// beat; directed, cooling and random tests run with random idling on both
// channels, off for the final random items, and several register settings.
// ----------------------------------------------------------------------------
`default_nettype none
module metropolis_accept_with_cooling_unit_test;
  import mac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        accepted;
    logic [16:0] prob;
    logic [31:0] temp_used;
    logic [31:0] total;
  } decision_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  mac_if #(.W(80)) in_if ();
  mac_if #(.W(82)) out_if ();

  metropolis_accept_with_cooling_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  logic [63:0] exp_table [0:256];
  logic [31:0] start_temp, temperature, accept_count;
  logic [15:0] cool_factor, cool_period, period_count;
  decision_t   pending_decisions [$];
  int          errors;
  int          cycles;
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void build_exp_table();
    logic [63:0] root;
    root = 64'd1 << 31;
    for (int i = 0; i < 8; i++) root = isqrt(root << 32);
    exp_table[0] = 64'd1 << 32;
    for (int i = 1; i < 257; i++) begin
      exp_table[i] = (exp_table[i-1] * root + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic logic [16:0] accept_prob(logic [31:0] cur, logic [31:0] prop,
                                              logic [31:0] t);
    longint      d;
    logic [63:0] x, y, f, val, diff, idx, rem;
    int          n;
    d = longint'($signed(prop)) - longint'($signed(cur));
    if (t == 0) return (d > 0) ? 17'd0 : PROB_ONE;
    if (d <= 0) return PROB_ONE;
    x = (64'(d) << 16) / 64'(t);
    if ((x >> 22) != 0) return 17'd0;
    y = (x * 64'd94548) >> 16;
    n = int'(y >> 16);
    if (n > 16) return 17'd0;
    f = y & 64'hFFFF;
    idx = f >> 8;
    rem = f & 64'hFF;
    diff = exp_table[idx] - exp_table[idx + 1];
    val = exp_table[idx] - ((diff * rem) >> 8);
    val = val >> (16 + n);
    return (val > 65536) ? PROB_ONE : val[16:0];
  endfunction

  function automatic decision_t predict_decision(logic [31:0] cur, logic [31:0] prop,
                                                 logic [15:0] sample);
    decision_t d;
    d.temp_used = temperature;
    d.prob = accept_prob(cur, prop, temperature);
    if (32'(period_count) + 1 >= 32'(cool_period)) begin
      period_count = 0;
      temperature = 32'((64'(temperature) * 64'(cool_factor)) >> 16);
    end else begin
      period_count = period_count + 1;
    end
    d.accepted = (17'(sample) <= d.prob);
    if (d.accepted && accept_count != 32'hFFFF_FFFF) accept_count = accept_count + 1;
    d.total = accept_count;
    return d;
  endfunction

  task automatic send_item(logic [31:0] cur, logic [31:0] prop, logic [15:0] sample);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= {cur, prop, sample};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_decisions.push_back(predict_decision(cur, prop, sample));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_START_TEMP: begin
        start_temp = value;
        temperature = value;
      end
      REG_COOL_FACTOR: cool_factor = value[15:0];
      REG_COOL_PERIOD: cool_period = value[15:0];
      default: ;
    endcase
  endtask

  task automatic send_random(int count);
    logic [31:0] cur, delta;
    for (int i = 0; i < count; i++) begin
      cur = $urandom;
      case ($urandom_range(0, 3))
        0: delta = $urandom;
        1: delta = $urandom_range(0, 32'h00FF_FFFF);
        2: delta = temperature >> $urandom_range(0, 6);
        default: delta = (temperature >> 4) * $urandom_range(0, 100);
      endcase
      if ($urandom_range(0, 4) == 0) delta = -delta;
      send_item(cur, cur + delta, 16'($urandom));
    end
  endtask

  task automatic test_directed();
    send_item(32'h0001_0000, 32'h0001_0000, 16'hFFFF);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_item(32'h0, 32'h0064_0000, 16'h0000);
    send_item(32'h0, 32'h0064_0000, 16'hFFFF);
    send_item(32'h0, 32'h0032_0000, 16'h5E2D);
    send_item(32'h0, 32'h0000_0001, 16'hFFFF);
    send_item(32'hFFFF_FFFF, 32'h0, 16'h8000);
    send_item(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
    send_item(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
    write_reg(REG_START_TEMP, 32'h0);
    send_item(32'h0, 32'h1, 16'h0000);
    send_item(32'h1, 32'h1, 16'hFFFF);
    send_item(32'h1, 32'h0, 16'hFFFF);
    write_reg(REG_START_TEMP, 32'hFFFF_FFFF);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 16'h0001);
    send_item(32'h0, 32'h0001_0000, 16'hFFFF);
  endtask

  task automatic test_cooling();
    write_reg(REG_COOL_PERIOD, 32'd1);
    write_reg(REG_COOL_FACTOR, 32'd65535);
    write_reg(REG_START_TEMP, 32'h0100_0000);
    send_random(20);
    write_reg(REG_COOL_FACTOR, 32'd0);
    send_random(5);
    write_reg(REG_START_TEMP, 32'h0010_0000);
    write_reg(REG_COOL_FACTOR, 32'd32768);
    write_reg(REG_COOL_PERIOD, 32'd3);
    send_random(12);
    write_reg(REG_COOL_PERIOD, 32'd0);
    send_random(6);
    write_reg(REG_COOL_PERIOD, 32'd65535);
    send_random(10);
  endtask

  task automatic test_random();
    write_reg(REG_START_TEMP, 32'h0064_0000);
    write_reg(REG_COOL_FACTOR, 32'd62259);
    write_reg(REG_COOL_PERIOD, 32'd7);
    send_random(150);
    write_reg(REG_START_TEMP, $urandom);
    write_reg(REG_COOL_FACTOR, $urandom_range(50000, 65535));
    write_reg(REG_COOL_PERIOD, $urandom_range(1, 20));
    send_random(150);
    idle_on = 1'b0;
    send_random(60);
  endtask

  initial begin
    ready_loop: forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    decision_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_decisions.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = pending_decisions.pop_front();
        if (got.accepted !== want.accepted) begin
          $display("%0t: accepted expected %0d actual %0d", $time, want.accepted,
                   got.accepted);
          errors++;
        end
        if (got.prob !== want.prob) begin
          $display("%0t: probability expected %0d actual %0d", $time, want.prob, got.prob);
          errors++;
        end
        if (got.temp_used !== want.temp_used) begin
          $display("%0t: temperature expected %h actual %h", $time, want.temp_used,
                   got.temp_used);
          errors++;
        end
        if (got.total !== want.total) begin
          $display("%0t: total expected %0d actual %0d", $time, want.total, got.total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_START_TEMP;
    cfg_data_i = 32'h0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b1;
    build_exp_table();
    start_temp = START_TEMP_RST;
    temperature = START_TEMP_RST;
    cool_factor = COOL_FACTOR_RST;
    cool_period = COOL_PERIOD_RST;
    period_count = 0;
    accept_count = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_cooling();
    test_random();
    drain();
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
